// ===== rtl/sat_pkg.sv =====
// Shared types and codes for the section address translator.
// Used by sat_ctrl, sat_datapath and section_address_translator_unit.
package sat_pkg;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_V2F  = 2'd1,
    MODE_F2V  = 2'd2,
    MODE_RSVD = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_LOADED     = 3'd0,
    ST_HEADER     = 3'd1,
    ST_TRANSLATED = 3'd2,
    ST_RANGE      = 3'd3,
    ST_NOSECT     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CFG_HEADERS_SIZE  = 2'd0,
    CFG_IMAGE_SIZE    = 2'd1,
    CFG_SECTION_COUNT = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ADDR_ZERO  = 2'd0,
    ADDR_QUERY = 2'd1,
    ADDR_XLATE = 2'd2
  } addr_sel_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_DECODE = 2'd1,
    S_LAST   = 2'd2,
    S_SCAN   = 2'd3
  } state_t;

  typedef struct packed {
    logic [31:0] vstart;
    logic [31:0] vsize;
    logic [31:0] fstart;
    logic [31:0] fsize;
  } section_t;

  // controller to datapath
  typedef struct packed {
    logic      capture;
    logic      mem_wr;
    logic      rd_en;
    logic      finish;
    status_t   status;
    addr_sel_t addr_sel;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_load;
    logic is_v2f;
    logic is_f2v;
    logic hdr;
    logic over_image;
    logic beyond_last;
    logic hit;
  } dp_stat_t;

endpackage

// ===== rtl/section_address_translator_unit.sv =====
// Section address translator: translates addresses between the virtual and
// file layouts of an image through a table of MAX_SECTIONS section entries.
// An item is accepted when start is high and busy is low; its result shows
// for one cycle with done high, and the receiver cannot stall it. Loads and
// header, virtual out-of-range and reserved queries finish at decode. A file
// query outside the headers with n nonzero (n = active section count) first
// reads the last entry and finishes if it lies past that section; else a
// search scans up to n entries, one entry per cycle, in the table memory
// with its one registered read port. Configuration writes are always ready
// and are applied at once; write them only while busy is low and no result
// is pending.
// Depends on sat_pkg, sat_ctrl and sat_datapath.
module section_address_translator_unit #(
  parameter int MAX_SECTIONS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [3:0]  entry_index,
  input  logic [31:0] query_address,
  input  logic [31:0] entry_virtual_start,
  input  logic [31:0] entry_virtual_size,
  input  logic [31:0] entry_file_start,
  input  logic [31:0] entry_file_size,
  output logic        done,
  output logic [31:0] translated_address,
  output logic [2:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int CNT_W = $clog2(MAX_SECTIONS + 1);

  sat_pkg::ctl_cmd_t cmd;
  sat_pkg::dp_stat_t stat;
  logic [CNT_W-1:0]  n;
  logic [IDX_W-1:0]  rd_addr;

  assign cfg_ready = 1'b1;

  sat_ctrl #(
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .stat    (stat),
    .n       (n),
    .cmd     (cmd),
    .rd_addr (rd_addr)
  );

  sat_datapath #(
    .MAX_SECTIONS (MAX_SECTIONS),
    .IDX_W        (IDX_W),
    .CNT_W        (CNT_W)
  ) u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_valid           (cfg_valid & cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .mode                (mode),
    .entry_index         (entry_index),
    .query_address       (query_address),
    .entry_virtual_start (entry_virtual_start),
    .entry_virtual_size  (entry_virtual_size),
    .entry_file_start    (entry_file_start),
    .entry_file_size     (entry_file_size),
    .cmd                 (cmd),
    .rd_addr             (rd_addr),
    .stat                (stat),
    .n                   (n),
    .done                (done),
    .translated_address  (translated_address),
    .status              (status)
  );

  // an accepted item keeps the block busy until its result is issued
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  // every result follows a cycle in which an item was in progress
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result issued with no item in progress");

  // a load always answers with a zero address
  assert property (@(posedge clk) disable iff (rst)
    (done && (status == sat_pkg::ST_LOADED)) |-> (translated_address == 32'd0))
    else $error("load result carries a nonzero address");

  // the table is never read when there are no active sections
  assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> (n != '0))
    else $error("table read with no active sections");

endmodule

// ===== rtl/sat_ctrl.sv =====
// Controller FSM for the section address translator: sequences decode,
// the last-section range check and the section scan. Depends on sat_pkg.
module sat_ctrl #(
  parameter int IDX_W = 4,
  parameter int CNT_W = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  sat_pkg::dp_stat_t    stat,
  input  logic [CNT_W-1:0]     n,
  output sat_pkg::ctl_cmd_t    cmd,
  output logic [IDX_W-1:0]     rd_addr
);

  sat_pkg::state_t   state, state_next;
  logic [CNT_W-1:0]  cursor, cursor_next;
  logic              pend, pend_next;
  logic [CNT_W-1:0]  last_idx;

  assign last_idx = n - 1'b1;
  assign busy     = (state != sat_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= sat_pkg::S_IDLE;
      cursor <= '0;
      pend   <= 1'b0;
    end else begin
      state  <= state_next;
      cursor <= cursor_next;
      pend   <= pend_next;
    end
  end

  always_comb begin
    state_next   = state;
    cursor_next  = cursor;
    pend_next    = pend;
    rd_addr      = cursor[IDX_W-1:0];
    cmd.capture  = 1'b0;
    cmd.mem_wr   = 1'b0;
    cmd.rd_en    = 1'b0;
    cmd.finish   = 1'b0;
    cmd.status   = sat_pkg::ST_RANGE;
    cmd.addr_sel = sat_pkg::ADDR_ZERO;
    case (state)
      sat_pkg::S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = sat_pkg::S_DECODE;
        end
      end
      sat_pkg::S_DECODE: begin
        cursor_next = '0;
        pend_next   = 1'b0;
        if (stat.is_load) begin
          cmd.mem_wr = 1'b1;
          cmd.finish = 1'b1;
          cmd.status = sat_pkg::ST_LOADED;
          state_next = sat_pkg::S_IDLE;
        end else if (!stat.is_v2f && !stat.is_f2v) begin
          cmd.finish = 1'b1;
          cmd.status = sat_pkg::ST_RANGE;
          state_next = sat_pkg::S_IDLE;
        end else if (stat.hdr) begin
          cmd.finish   = 1'b1;
          cmd.status   = sat_pkg::ST_HEADER;
          cmd.addr_sel = sat_pkg::ADDR_QUERY;
          state_next   = sat_pkg::S_IDLE;
        end else if (stat.is_v2f && stat.over_image) begin
          cmd.finish = 1'b1;
          cmd.status = sat_pkg::ST_RANGE;
          state_next = sat_pkg::S_IDLE;
        end else if (stat.is_f2v && (n != '0)) begin
          // fetch the last section for the file range check
          cmd.rd_en  = 1'b1;
          rd_addr    = last_idx[IDX_W-1:0];
          state_next = sat_pkg::S_LAST;
        end else begin
          state_next = sat_pkg::S_SCAN;
        end
      end
      sat_pkg::S_LAST: begin
        if (stat.beyond_last) begin
          cmd.finish   = 1'b1;
          cmd.status   = sat_pkg::ST_RANGE;
          cmd.addr_sel = sat_pkg::ADDR_QUERY;
          state_next   = sat_pkg::S_IDLE;
        end else begin
          state_next = sat_pkg::S_SCAN;
        end
      end
      sat_pkg::S_SCAN: begin
        // check the entry read last cycle while fetching the next one
        if (pend && stat.hit) begin
          cmd.finish   = 1'b1;
          cmd.status   = sat_pkg::ST_TRANSLATED;
          cmd.addr_sel = sat_pkg::ADDR_XLATE;
          state_next   = sat_pkg::S_IDLE;
        end else if (cursor < n) begin
          cmd.rd_en   = 1'b1;
          cursor_next = cursor + 1'b1;
          pend_next   = 1'b1;
        end else begin
          cmd.finish   = 1'b1;
          cmd.status   = sat_pkg::ST_NOSECT;
          cmd.addr_sel = stat.is_f2v ? sat_pkg::ADDR_QUERY : sat_pkg::ADDR_ZERO;
          state_next   = sat_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sat_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/sat_datapath.sv =====
// Datapath for the section address translator: configuration registers,
// section table memory, range compares and result registers. Depends on sat_pkg.
module sat_datapath #(
  parameter int MAX_SECTIONS = 16,
  parameter int IDX_W        = 4,
  parameter int CNT_W        = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic [1:0]           mode,
  input  logic [3:0]           entry_index,
  input  logic [31:0]          query_address,
  input  logic [31:0]          entry_virtual_start,
  input  logic [31:0]          entry_virtual_size,
  input  logic [31:0]          entry_file_start,
  input  logic [31:0]          entry_file_size,
  input  sat_pkg::ctl_cmd_t    cmd,
  input  logic [IDX_W-1:0]     rd_addr,
  output sat_pkg::dp_stat_t    stat,
  output logic [CNT_W-1:0]     n,
  output logic                 done,
  output logic [31:0]          translated_address,
  output logic [2:0]           status
);

  logic [31:0]       headers_size;
  logic [31:0]       image_size;
  logic [4:0]        section_count;

  sat_pkg::mode_t    mode_r;
  logic [3:0]        idx_r;
  logic [31:0]       addr_r;
  sat_pkg::section_t entry_r;

  sat_pkg::section_t mem [MAX_SECTIONS];
  sat_pkg::section_t rdata;

  logic [7:0]        cnt_ext;
  logic [7:0]        n_wide;
  logic [7:0]        idx_ext;
  logic              idx_ok;

  logic [31:0]       start_sel;
  logic [31:0]       size_sel;
  logic [31:0]       base_sel;
  logic [32:0]       end_sel;
  logic [32:0]       last_end;
  logic [31:0]       xlate;

  always_ff @(posedge clk) begin
    if (rst) begin
      headers_size  <= '0;
      image_size    <= '0;
      section_count <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        sat_pkg::CFG_HEADERS_SIZE:  headers_size  <= cfg_data;
        sat_pkg::CFG_IMAGE_SIZE:    image_size    <= cfg_data;
        sat_pkg::CFG_SECTION_COUNT: section_count <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // clamp the entry count to the table depth
  assign cnt_ext = {3'b000, section_count};
  assign n_wide  = (cnt_ext > 8'(MAX_SECTIONS)) ? 8'(MAX_SECTIONS) : cnt_ext;
  assign n       = n_wide[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r         <= sat_pkg::mode_t'(mode);
      idx_r          <= entry_index;
      addr_r         <= query_address;
      entry_r.vstart <= entry_virtual_start;
      entry_r.vsize  <= entry_virtual_size;
      entry_r.fstart <= entry_file_start;
      entry_r.fsize  <= entry_file_size;
    end
  end

  assign idx_ext = {4'b0000, idx_r};
  assign idx_ok  = (idx_ext < 8'(MAX_SECTIONS));

  always_ff @(posedge clk) begin
    if (cmd.mem_wr && idx_ok) begin
      mem[idx_ext[IDX_W-1:0]] <= entry_r;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  assign stat.is_load = (mode_r == sat_pkg::MODE_LOAD);
  assign stat.is_v2f  = (mode_r == sat_pkg::MODE_V2F);
  assign stat.is_f2v  = (mode_r == sat_pkg::MODE_F2V);
  assign stat.hdr        = (addr_r < headers_size);
  assign stat.over_image = (addr_r > image_size);

  assign last_end         = {1'b0, rdata.fstart} + {1'b0, rdata.fsize};
  assign stat.beyond_last = ({1'b0, addr_r} > last_end);

  assign start_sel = stat.is_f2v ? rdata.fstart : rdata.vstart;
  assign size_sel  = stat.is_f2v ? rdata.fsize  : rdata.vsize;
  assign base_sel  = stat.is_f2v ? rdata.vstart : rdata.fstart;
  assign end_sel   = {1'b0, start_sel} + {1'b0, size_sel};
  assign stat.hit  = (addr_r >= start_sel) && ({1'b0, addr_r} <= end_sel);
  assign xlate     = base_sel + (addr_r - start_sel);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status <= cmd.status;
      case (cmd.addr_sel)
        sat_pkg::ADDR_QUERY: translated_address <= addr_r;
        sat_pkg::ADDR_XLATE: translated_address <= xlate;
        default:             translated_address <= '0;
      endcase
    end
  end

endmodule

// ===== test/tb_section_address_translator_unit.sv =====
`timescale 1ns / 1ps
// Testbench for section_address_translator_unit: directed and random load and query items,
// each result checked against an in-bench model of the section table.
// Depends on sat_pkg and the translator RTL.
module tb_section_address_translator_unit;

  localparam int TABLE_DEPTH = 16;
  localparam int MAX_GAP = 11;
  localparam int QUERIES_PER_LAYOUT = 110;
  localparam int MAX_PRINTED = 50;

  typedef struct {
    sat_pkg::mode_t mode;
    logic [3:0]     entry;
    logic [31:0]    addr;
    logic [31:0]    vstart;
    logic [31:0]    vsize;
    logic [31:0]    fstart;
    logic [31:0]    fsize;
  } xlate_req_t;

  typedef struct {
    logic [31:0]      addr;
    sat_pkg::status_t status;
  } xlate_rsp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  mode = sat_pkg::MODE_LOAD;
  logic [3:0]  entry_index = '0;
  logic [31:0] query_address = '0;
  logic [31:0] entry_virtual_start = '0;
  logic [31:0] entry_virtual_size = '0;
  logic [31:0] entry_file_start = '0;
  logic [31:0] entry_file_size = '0;
  logic        done;
  logic [31:0] translated_address;
  logic [2:0]  status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = sat_pkg::CFG_HEADERS_SIZE;
  logic [31:0] cfg_data = '0;

  // model copy of the section table and registers
  logic [31:0] tbl_vstart [TABLE_DEPTH];
  logic [31:0] tbl_vsize  [TABLE_DEPTH];
  logic [31:0] tbl_fstart [TABLE_DEPTH];
  logic [31:0] tbl_fsize  [TABLE_DEPTH];
  logic [31:0] cur_headers = '0;
  logic [31:0] cur_image = '0;
  logic [4:0]  cur_count = '0;

  xlate_rsp_t  pending_xlate [$];
  int unsigned error_count = 0;
  bit          no_idle = 1'b0;

  section_address_translator_unit #(
    .MAX_SECTIONS(TABLE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .entry_index(entry_index),
    .query_address(query_address),
    .entry_virtual_start(entry_virtual_start),
    .entry_virtual_size(entry_virtual_size),
    .entry_file_start(entry_file_start),
    .entry_file_size(entry_file_size),
    .done(done),
    .translated_address(translated_address),
    .status(status),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit in_section(input logic [31:0] base, input logic [31:0] size,
                                    input logic [31:0] a);
    logic [32:0] lim;
    lim = {1'b0, base} + {1'b0, size};
    return (a >= base) && ({1'b0, a} <= lim);
  endfunction

  function automatic xlate_rsp_t translate_item(input xlate_req_t r);
    xlate_rsp_t  rsp;
    int          n;
    logic [32:0] last_end;
    n = (cur_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(cur_count);
    rsp.addr = '0;
    rsp.status = sat_pkg::ST_RANGE;
    case (r.mode)
      sat_pkg::MODE_LOAD: begin
        tbl_vstart[r.entry] = r.vstart;
        tbl_vsize[r.entry] = r.vsize;
        tbl_fstart[r.entry] = r.fstart;
        tbl_fsize[r.entry] = r.fsize;
        rsp.status = sat_pkg::ST_LOADED;
      end
      sat_pkg::MODE_V2F: begin
        if (r.addr < cur_headers) begin
          rsp.addr = r.addr;
          rsp.status = sat_pkg::ST_HEADER;
        end else if (r.addr <= cur_image) begin
          rsp.status = sat_pkg::ST_NOSECT;
          // scan from the top so the lowest matching entry is the one kept
          for (int i = n - 1; i >= 0; i--) begin
            if (in_section(tbl_vstart[i], tbl_vsize[i], r.addr)) begin
              rsp.addr = tbl_fstart[i] + (r.addr - tbl_vstart[i]);
              rsp.status = sat_pkg::ST_TRANSLATED;
            end
          end
        end
      end
      sat_pkg::MODE_F2V: begin
        rsp.addr = r.addr;
        last_end = '1;
        if (n > 0) last_end = {1'b0, tbl_fstart[n-1]} + {1'b0, tbl_fsize[n-1]};
        if (r.addr < cur_headers) begin
          rsp.status = sat_pkg::ST_HEADER;
        end else if ({1'b0, r.addr} > last_end) begin
          rsp.status = sat_pkg::ST_RANGE;
        end else begin
          rsp.status = sat_pkg::ST_NOSECT;
          for (int i = n - 1; i >= 0; i--) begin
            if (in_section(tbl_fstart[i], tbl_fsize[i], r.addr)) begin
              rsp.addr = tbl_vstart[i] + (r.addr - tbl_fstart[i]);
              rsp.status = sat_pkg::ST_TRANSLATED;
            end
          end
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  function automatic xlate_req_t make_query(input sat_pkg::mode_t m, input logic [31:0] a);
    xlate_req_t r;
    r.mode = m;
    r.entry = 4'($urandom);
    r.addr = a;
    r.vstart = $urandom;
    r.vsize = $urandom;
    r.fstart = $urandom;
    r.fsize = $urandom;
    return r;
  endfunction

  function automatic xlate_req_t make_load(input logic [3:0] e, input logic [31:0] vs,
                                           input logic [31:0] vz, input logic [31:0] fs,
                                           input logic [31:0] fz);
    xlate_req_t r;
    r.mode = sat_pkg::MODE_LOAD;
    r.entry = e;
    r.addr = $urandom;
    r.vstart = vs;
    r.vsize = vz;
    r.fstart = fs;
    r.fsize = fz;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= MAX_PRINTED)
      $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
  endtask

  // Called right after a rising edge; returns at the edge that accepts the item,
  // leaving start high so a back-to-back item needs no second assignment.
  task automatic send_item(input xlate_req_t r);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    mode <= r.mode;
    entry_index <= r.entry;
    query_address <= r.addr;
    entry_virtual_start <= r.vstart;
    entry_virtual_size <= r.vsize;
    entry_file_start <= r.fstart;
    entry_file_size <= r.fsize;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_xlate.push_back(translate_item(r));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_xlate.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input sat_pkg::cfg_reg_t idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      sat_pkg::CFG_HEADERS_SIZE:  cur_headers = val;
      sat_pkg::CFG_IMAGE_SIZE:    cur_image = val;
      sat_pkg::CFG_SECTION_COUNT: cur_count = val[4:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] hdr, input logic [31:0] img,
                            input logic [4:0] cnt);
    drain();
    write_reg(sat_pkg::CFG_HEADERS_SIZE, hdr);
    write_reg(sat_pkg::CFG_IMAGE_SIZE, img);
    write_reg(sat_pkg::CFG_SECTION_COUNT, {27'd0, cnt});
  endtask

  // check each result against the oldest pending transfer
  always @(posedge clk) begin
    xlate_rsp_t want;
    if (!rst && done) begin
      if (pending_xlate.size() == 0) begin
        report_mismatch("result with no item pending", translated_address, '0);
      end else begin
        want = pending_xlate.pop_front();
        if (translated_address !== want.addr)
          report_mismatch("translated_address", translated_address, want.addr);
        if (status !== want.status)
          report_mismatch("status", {29'd0, status}, {29'd0, want.status});
      end
    end
  end

  task automatic test_section_load();
    send_item(make_load(4'd0, 32'h0000_1000, 32'h0000_1000, 32'h0000_0400, 32'h0000_0800));
    send_item(make_load(4'd1, 32'h0000_2000, 32'h0000_2000, 32'h0000_0C00, 32'h0000_2000));
    // ends past 2^32 in both layouts; file base makes translations wrap
    send_item(make_load(4'd2, 32'hFFFF_FF00, 32'hFFFF_FFFF, 32'hFFFF_FF80, 32'hFFFF_FFFF));
    send_item(make_load(4'd3, 32'h0000_9000, 32'h0000_0000, 32'h0000_4000, 32'h0000_0000));
  endtask

  task automatic test_virtual_queries();
    set_config(32'h0000_0400, 32'hFFFF_FFFF, 5'd3);
    send_item(make_query(sat_pkg::MODE_V2F, 32'h0000_03FF));
    send_item(make_query(sat_pkg::MODE_V2F, 32'h0000_0400));
    // upper bound of entry 0 also starts entry 1: first entry wins
    send_item(make_query(sat_pkg::MODE_V2F, 32'h0000_2000));
    send_item(make_query(sat_pkg::MODE_V2F, 32'h0000_2001));
    send_item(make_query(sat_pkg::MODE_V2F, 32'hFFFF_FFFF));
    set_config(32'h0000_0400, 32'h0000_3000, 5'd3);
    send_item(make_query(sat_pkg::MODE_V2F, 32'h0000_3001));
    send_item(make_query(sat_pkg::MODE_V2F, 32'h0000_3000));
  endtask

  task automatic test_file_queries();
    set_config(32'h0000_0400, 32'hFFFF_FFFF, 5'd4);
    send_item(make_query(sat_pkg::MODE_F2V, 32'h0000_0400));
    send_item(make_query(sat_pkg::MODE_F2V, 32'h0000_4000));
    send_item(make_query(sat_pkg::MODE_F2V, 32'h0000_4001));
    send_item(make_query(sat_pkg::MODE_F2V, 32'h0000_3000));
    set_config(32'h0000_0400, 32'hFFFF_FFFF, 5'd3);
    send_item(make_query(sat_pkg::MODE_F2V, 32'hFFFF_FFFF));
  endtask

  task automatic test_config_extremes();
    set_config(32'h0000_0000, 32'h0000_3000, 5'd0);
    send_item(make_query(sat_pkg::MODE_V2F, 32'h0000_0500));
    send_item(make_query(sat_pkg::MODE_F2V, 32'h0000_0500));
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd2);
    send_item(make_query(sat_pkg::MODE_V2F, 32'hFFFF_FFFE));
    send_item(make_query(sat_pkg::MODE_F2V, 32'h0000_0000));
    send_item(make_query(sat_pkg::MODE_V2F, 32'hFFFF_FFFF));
    set_config(32'h0000_0000, 32'h0000_0000, 5'd2);
    send_item(make_query(sat_pkg::MODE_V2F, 32'h0000_0001));
    send_item(make_query(sat_pkg::MODE_V2F, 32'h0000_0000));
    send_item(make_query(sat_pkg::MODE_RSVD, 32'h0000_1000));
  endtask

  task automatic test_random_layouts(input int layouts);
    logic [31:0] vcur, fcur, vz, fz, a, base, span, hdr, img;
    logic [4:0]  cnt;
    int          n, j, sel;
    bit          noise, virt;
    for (int p = 0; p < layouts; p++) begin
      no_idle = ($urandom_range(0, 3) == 0);
      noise = ($urandom_range(0, 3) == 0);
      vcur = $urandom_range(0, 32'h0010_0000);
      fcur = $urandom_range(0, 32'h0000_1000);
      // fill every entry before any query can read it
      for (int k = 0; k < TABLE_DEPTH; k++) begin
        if (noise) begin
          send_item(make_load(4'(k), $urandom, $urandom, $urandom, $urandom));
        end else begin
          vz = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 32'h3000);
          fz = ($urandom_range(0, 1) == 0) ? vz : $urandom_range(0, 32'h3000);
          send_item(make_load(4'(k), vcur, vz, fcur, fz));
          vcur = vcur + vz + $urandom_range(0, 32'h400);
          fcur = fcur + fz + $urandom_range(0, 32'h200);
        end
      end

      case ($urandom_range(0, 4))
        0: hdr = '0;
        1: hdr = '1;
        2: hdr = $urandom;
        default: hdr = $urandom_range(0, 32'h1000);
      endcase
      case ($urandom_range(0, 7))
        0: img = '0;
        1: img = '1;
        2: img = $urandom;
        default: img = vcur + $urandom_range(0, 32'h100);
      endcase
      if (p == 0) cnt = 5'd31;
      else if (p == 1) cnt = 5'd16;
      else if (p == 2) cnt = 5'd0;
      else if ($urandom_range(0, 4) == 0) cnt = 5'($urandom_range(17, 31));
      else cnt = 5'($urandom_range(1, 16));
      set_config(hdr, img, cnt);
      n = (cnt > TABLE_DEPTH) ? TABLE_DEPTH : int'(cnt);

      for (int q = 0; q < QUERIES_PER_LAYOUT; q++) begin
        j = (n > 0) ? $urandom_range(0, n - 1) : $urandom_range(0, TABLE_DEPTH - 1);
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
          // inside a section, on its ends or just past its upper end
          virt = (sel < 40);
          base = virt ? tbl_vstart[j] : tbl_fstart[j];
          span = virt ? tbl_vsize[j] : tbl_fsize[j];
          case ($urandom_range(0, 3))
            0: a = base;
            1: a = base + span;
            2: a = base + span + 1;
            default: a = base + $urandom_range(0, span);
          endcase
          send_item(make_query(virt ? sat_pkg::MODE_V2F : sat_pkg::MODE_F2V, a));
        end else if (sel < 78) begin
          a = cur_headers + $urandom_range(0, 2) - 1;
          send_item(make_query(($urandom_range(0, 1) == 0) ? sat_pkg::MODE_V2F
                                                             : sat_pkg::MODE_F2V, a));
        end else if (sel < 84) begin
          a = cur_image + $urandom_range(0, 2) - 1;
          send_item(make_query(sat_pkg::MODE_V2F, a));
        end else if (sel < 90) begin
          a = (n > 0) ? tbl_fstart[n-1] + tbl_fsize[n-1] : $urandom;
          send_item(make_query(sat_pkg::MODE_F2V, a + $urandom_range(0, 2) - 1));
        end else if (sel < 94) begin
          send_item(make_load(4'($urandom), $urandom, $urandom_range(0, 32'h3000),
                              $urandom, $urandom_range(0, 32'h3000)));
        end else begin
          send_item(make_query(sat_pkg::mode_t'($urandom_range(0, 3)), $urandom));
        end
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_section_load();
    test_virtual_queries();
    test_file_queries();
    test_config_extremes();
    test_random_layouts(8);
    drain();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
